/* design/spmd_pkg.sv */
// Shared types and constants for the sorted prefix max distance block.
package spmd_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned DIST_WIDTH_DEF  = 32;

  localparam int unsigned IN_TDATA_W  = 32;  // dist_value
  localparam int unsigned IN_TUSER_W  = 1;   // is_related
  localparam int unsigned OUT_TDATA_W = 32;  // max_reach
  localparam int unsigned OUT_TUSER_W = 1;   // overflowed

  // Result of one magnitude compare of a against b.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

/* design/sorted_prefix_max_distance.sv */
// Top level: entry store, scan sequencer and output register.
//
// Usage. The in_ channel carries one entry per word: in_tdata is the distance
// (unsigned Q16.16), in_tuser the related flag and in_tlast closes the set.
// Entries load at one word per cycle while in_tready is high, into an internal
// store of MAX_ENTRIES rows; words beyond that depth are dropped and the set
// is marked overflowed. The word with in_tlast starts two passes over the N
// stored entries through one shared comparator: the first finds the earliest
// smallest unrelated distance (store read, compare), the second takes the
// largest related distance that sorts ahead of it (store read, compare against
// the unrelated bound, compare against the best so far). in_tready is low
// during the passes. The result sits in an output register: while the
// receiver stalls it holds, and the next set still loads; only the end of
// the next scan waits for the register to drain.
// out_tdata is max_reach, out_tuser is overflowed. Reset empties the store
// count, clears the overflow mark and drops any pending result word.
module sorted_prefix_max_distance #(
  parameter int unsigned MAX_ENTRIES = spmd_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned DIST_WIDTH  = spmd_pkg::DIST_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spmd_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] dist_value
  input  logic [spmd_pkg::IN_TUSER_W-1:0]    in_tuser,   // [0] is_related
  input  logic                               in_tlast,   // end_of_set
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spmd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [31:0] max_reach
  output logic [spmd_pkg::OUT_TUSER_W-1:0]   out_tuser   // [0] overflowed
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IN_EXT_W =
    (DIST_WIDTH > spmd_pkg::IN_TDATA_W) ? DIST_WIDTH : spmd_pkg::IN_TDATA_W;
  localparam int unsigned OUT_EXT_W =
    (DIST_WIDTH > spmd_pkg::OUT_TDATA_W) ? DIST_WIDTH : spmd_pkg::OUT_TDATA_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_U_RD,
    ST_U_CMP,
    ST_R_RD,
    ST_R_CMPU,
    ST_R_CMPB,
    ST_DONE
  } state_t;

  // Store: distance in the low bits, related flag on top.
  logic [DIST_WIDTH:0]   mem [MAX_ENTRIES];
  logic [DIST_WIDTH:0]   rd_q;
  logic [IDX_W-1:0]      rd_addr;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  have_u_r, have_u_nxt;
  logic [DIST_WIDTH-1:0] umin_r, umin_nxt;
  logic [IDX_W-1:0]      uidx_r, uidx_nxt;
  logic [DIST_WIDTH-1:0] best_r, best_nxt;
  logic                  elig_r, elig_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [spmd_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  in_acc;
  logic                  full;
  logic                  wr_en;
  logic [IN_EXT_W-1:0]   din_ext;
  logic [DIST_WIDTH-1:0] din_dist;
  logic [OUT_EXT_W-1:0]  best_ext;
  logic                  last_idx;
  logic [DIST_WIDTH-1:0] rd_dist;
  logic                  rd_rel;
  logic [DIST_WIDTH-1:0] cmp_b;
  spmd_pkg::cmp_res_t    cmp_res;

  assign in_tready  = (state_r == ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign full       = (cnt_r == CNT_W'(MAX_ENTRIES));
  assign wr_en      = in_acc && !full;
  assign din_ext    = IN_EXT_W'(in_tdata);
  assign din_dist   = din_ext[DIST_WIDTH-1:0];
  assign best_ext   = OUT_EXT_W'(best_r);
  assign last_idx   = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign rd_dist    = rd_q[DIST_WIDTH-1:0];
  assign rd_rel     = rd_q[DIST_WIDTH];
  assign rd_addr    = idx_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

  // Write on load, registered read during the scans.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= {in_tuser[0], din_dist};
    end
    rd_q <= mem[rd_addr];
  end

  // One comparator: against the unrelated bound, or against the best so far.
  assign cmp_b = (state_r == ST_R_CMPB) ? best_r : umin_r;

  spmd_cmp #(
    .W (DIST_WIDTH)
  ) u_cmp (
    .a   (rd_dist),
    .b   (cmp_b),
    .res (cmp_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    have_u_nxt    = have_u_r;
    umin_nxt      = umin_r;
    uidx_nxt      = uidx_r;
    best_nxt      = best_r;
    elig_nxt      = elig_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ovf_nxt   = out_ovf_r;

    // Drop the result word once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_tlast) begin
            idx_nxt    = '0;
            have_u_nxt = 1'b0;
            state_nxt  = ST_U_RD;
          end
        end
      end
      ST_U_RD: begin
        state_nxt = ST_U_CMP;
      end
      ST_U_CMP: begin
        // Keep the earliest of the smallest unrelated distances.
        if (!rd_rel && (!have_u_r || cmp_res.lt)) begin
          have_u_nxt = 1'b1;
          umin_nxt   = rd_dist;
          uidx_nxt   = idx_r;
        end
        if (last_idx) begin
          idx_nxt   = '0;
          best_nxt  = '0;
          state_nxt = ST_R_RD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_U_RD;
        end
      end
      ST_R_RD: begin
        state_nxt = ST_R_CMPU;
      end
      ST_R_CMPU: begin
        // Related and sorted ahead of the first unrelated entry.
        elig_nxt  = rd_rel && (!have_u_r || cmp_res.lt ||
                               (cmp_res.eq && (idx_r < uidx_r)));
        state_nxt = ST_R_CMPB;
      end
      ST_R_CMPB: begin
        if (elig_r && !cmp_res.lt && !cmp_res.eq) begin
          best_nxt = rd_dist;
        end
        if (last_idx) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_R_RD;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_nxt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_ext[spmd_pkg::OUT_TDATA_W-1:0];
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    have_u_r   <= have_u_nxt;
    umin_r     <= umin_nxt;
    uidx_r     <= uidx_nxt;
    best_r     <= best_nxt;
    elig_r     <= elig_nxt;
    out_data_r <= out_data_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

/* design/spmd_cmp.sv */
// Shared unsigned magnitude comparator used by every compare step of the scans.
module spmd_cmp #(
  parameter int unsigned W = spmd_pkg::DIST_WIDTH_DEF
) (
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output spmd_pkg::cmp_res_t res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

/* design/spmd_checker.sv */
// Port-level checks for the sorted prefix max distance block, bound to the top.
module spmd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [spmd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [spmd_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // Reset leaves the loader open and no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("block not idle after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result word changed while stalled");

  // Loading a non-final word never closes the loader.
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tlast) |=> in_tready)
    else $error("loader stalled mid-set");

  // The closing word starts the scan, which holds off input.
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input taken during scan");

endmodule

bind sorted_prefix_max_distance spmd_checker u_spmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
